// ===== rtl/brlt_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants shared by the byte-range lock table.
package brlt_pkg;

    localparam logic [62:0] OFF_MAX = '1;

    localparam logic [1:0] LT_READ   = 2'd0;
    localparam logic [1:0] LT_WRITE  = 2'd1;
    localparam logic [1:0] LT_UNLOCK = 2'd2;

    localparam logic ACT_TEST = 1'b0;
    localparam logic ACT_SET  = 1'b1;

    typedef struct packed {
        logic [63:0] owner;
        logic        is_write;
        logic [62:0] first;
        logic [62:0] last;
        logic [21:0] pid;
    } t_entry;

    typedef struct packed {
        logic        action;
        logic [63:0] owner;
        logic [21:0] pid;
        logic [1:0]  lock_type;
        logic [62:0] start_req;
        logic [62:0] length;
    } t_req;

    typedef struct packed {
        logic        status;
        logic        conflict_found;
        logic        conflict_type;
        logic [62:0] conflict_start;
        logic [62:0] conflict_length;
        logic [21:0] conflict_pid;
    } t_rsp;

endpackage

// ===== rtl/brlt_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channels for lock requests and their results.
interface brlt_req_if import brlt_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface brlt_rsp_if import brlt_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/byte_range_lock_table.sv =====
`timescale 1ns / 1ps
// Byte-range lock table: ordered lock entries kept in two ping-pong memories.
// A test scans the stored locks one entry per cycle and stops at the first conflict.
// A set scans the stored locks and writes the resulting entries to the other memory bank
// through its single write port; the scan waits while entries are written.
// Synchronous reset empties the table and clears all control state.
module byte_range_lock_table import brlt_pkg::*; #(
    parameter int MAX_LOCKS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    brlt_req_if.sink    i_req,
    brlt_rsp_if.source  o_rsp
);

    localparam int IW = $clog2(MAX_LOCKS);
    localparam int CW = $clog2(MAX_LOCKS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EV   = 3'd2;
    localparam logic [2:0] S_EM   = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_RES  = 3'd5;

    t_entry mem0 [MAX_LOCKS];
    t_entry mem1 [MAX_LOCKS];

    logic [2:0]    r_state, n_state;
    logic          r_bank, n_bank;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_wcnt, n_wcnt;
    logic [CW-1:0] r_i, n_i;
    logic          r_act, n_act;
    logic [63:0]   r_own, n_own;
    logic [21:0]   r_pid, n_pid;
    logic [1:0]    r_nt, n_nt;
    logic [62:0]   r_ns, n_ns;
    logic [62:0]   r_ne, n_ne;
    logic          r_done, n_done;
    t_entry        r_q [3];
    t_entry        n_q [3];
    logic [1:0]    r_qn, n_qn;
    logic [1:0]    r_qk, n_qk;
    t_rsp          r_rsp, n_rsp;
    t_rsp          r_out, n_out;
    logic          r_ovalid, n_ovalid;
    t_entry        r_rd0, r_rd1;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          we;
    t_entry        e, ent_new, ent_tail;
    logic [1:0]    nt_in;
    logic [63:0]   end_sum;
    logic [62:0]   end_in;
    logic          whole, noroom, last, conflict;
    logic [CW-1:0] nxt_i;
    logic signed [63:0] ef, el, sns, sne, nsm1, nep1, efm1;
    t_entry        q [3];
    logic [1:0]    qn;
    logic          ev_done, ev_abort;
    logic [62:0]   m_ns, m_ne;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd0 <= mem0[rd_addr];
            r_rd1 <= mem1[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we && r_bank) begin
            mem0[r_wcnt[IW-1:0]] <= r_q[r_qk];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we && !r_bank) begin
            mem1[r_wcnt[IW-1:0]] <= r_q[r_qk];
        end
    end

    always_comb begin
        nt_in   = (i_req.data.lock_type == 2'd3) ? LT_UNLOCK : i_req.data.lock_type;
        end_sum = {1'b0, i_req.data.start_req} + {1'b0, i_req.data.length} - 64'd1;
        if (i_req.data.length == '0 || end_sum[63]) begin
            end_in = OFF_MAX;
        end else begin
            end_in = end_sum[62:0];
        end
        whole  = (nt_in == LT_UNLOCK) && (i_req.data.start_req == '0) && (end_in == OFF_MAX);
        noroom = !whole && (({1'b0, r_cnt} + (CW+1)'(2)) > (CW+1)'(MAX_LOCKS));

        e     = r_bank ? r_rd1 : r_rd0;
        nxt_i = r_i + CW'(1);
        last  = (nxt_i == r_cnt);
        ef    = {1'b0, e.first};
        el    = {1'b0, e.last};
        sns   = {1'b0, r_ns};
        sne   = {1'b0, r_ne};
        nsm1  = sns - 64'sd1;
        nep1  = sne + 64'sd1;
        efm1  = ef - 64'sd1;
        ent_new = '{owner: r_own, is_write: (r_nt == LT_WRITE), first: r_ns, last: r_ne,
                    pid: r_pid};
        conflict = (e.owner != r_own) && (sns <= el) && (ef <= sne)
                   && (e.is_write || r_nt == LT_WRITE);

        q[0] = e;
        q[1] = e;
        q[2] = e;
        qn = 2'd1;
        ev_done = r_done;
        ev_abort = 1'b0;
        m_ns = r_ns;
        m_ne = r_ne;
        if (r_done || e.owner != r_own) begin
            qn = 2'd1;
        end else if ((e.is_write ? LT_WRITE : LT_READ) == r_nt) begin
            if (el < nsm1) begin
                qn = 2'd1;
            end else if (sne < efm1) begin
                q[0] = ent_new;
                q[1] = e;
                qn = 2'd2;
                ev_done = 1'b1;
            end else if (ef <= sns && sne <= el) begin
                qn = 2'd0;
                ev_abort = 1'b1;
            end else begin
                if (ef < sns) m_ns = e.first;
                if (sne < el) m_ne = e.last;
                qn = 2'd0;
            end
        end else begin
            if (el < sns) begin
                qn = 2'd1;
            end else if (sne < ef) begin
                ev_done = 1'b1;
                if (r_nt != LT_UNLOCK) begin
                    q[0] = ent_new;
                    q[1] = e;
                    qn = 2'd2;
                end
            end else if (sns <= ef && el <= sne) begin
                qn = 2'd0;
            end else if (el <= sne) begin
                q[0].last = nsm1[62:0];
            end else if (sns <= ef) begin
                ev_done = 1'b1;
                if (r_nt != LT_UNLOCK) begin
                    q[0] = ent_new;
                    q[1].first = nep1[62:0];
                    qn = 2'd2;
                end else begin
                    q[0].first = nep1[62:0];
                end
            end else begin
                ev_done = 1'b1;
                q[0].last = nsm1[62:0];
                if (r_nt != LT_UNLOCK) begin
                    q[1] = ent_new;
                    q[2].first = nep1[62:0];
                    qn = 2'd3;
                end else begin
                    q[1].first = nep1[62:0];
                    qn = 2'd2;
                end
            end
        end
        ent_tail = '{owner: r_own, is_write: (r_nt == LT_WRITE), first: m_ns, last: m_ne,
                     pid: r_pid};
        if (last && !ev_done && !ev_abort && r_nt != LT_UNLOCK) begin
            if (qn == 2'd0) begin
                q[0] = ent_tail;
            end else begin
                q[1] = ent_tail;
            end
            qn = qn + 2'd1;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_bank   = r_bank;
        n_cnt    = r_cnt;
        n_wcnt   = r_wcnt;
        n_i      = r_i;
        n_act    = r_act;
        n_own    = r_own;
        n_pid    = r_pid;
        n_nt     = r_nt;
        n_ns     = r_ns;
        n_ne     = r_ne;
        n_done   = r_done;
        n_q      = r_q;
        n_qn     = r_qn;
        n_qk     = r_qk;
        n_rsp    = r_rsp;
        n_out    = r_out;
        n_ovalid = r_ovalid && !o_rsp.ready;
        rd_en    = 1'b0;
        rd_addr  = r_i[IW-1:0];
        we       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_act  = i_req.data.action;
                    n_own  = i_req.data.owner;
                    n_pid  = i_req.data.pid;
                    n_nt   = nt_in;
                    n_ns   = i_req.data.start_req;
                    n_ne   = end_in;
                    n_i    = '0;
                    n_wcnt = '0;
                    n_done = 1'b0;
                    n_qk   = '0;
                    n_rsp  = '0;
                    if (i_req.data.action == ACT_TEST) begin
                        n_state = (r_cnt == '0) ? S_RES : S_RD;
                    end else if (noroom) begin
                        n_rsp.status = 1'b1;
                        n_state = S_RES;
                    end else if (r_cnt != '0) begin
                        n_state = S_RD;
                    end else if (nt_in != LT_UNLOCK) begin
                        n_q[0] = '{owner: i_req.data.owner, is_write: (nt_in == LT_WRITE),
                                   first: i_req.data.start_req, last: end_in,
                                   pid: i_req.data.pid};
                        n_qn = 2'd1;
                        n_state = S_EM;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_RD: begin
                rd_en   = 1'b1;
                n_state = S_EV;
            end
            S_EV: begin
                rd_en   = 1'b1;
                rd_addr = nxt_i[IW-1:0];
                n_i     = nxt_i;
                if (r_act == ACT_TEST) begin
                    if (conflict) begin
                        n_rsp.conflict_found  = 1'b1;
                        n_rsp.conflict_type   = e.is_write;
                        n_rsp.conflict_start  = e.first;
                        n_rsp.conflict_length = (e.last == OFF_MAX) ? '0
                                              : (e.last - e.first + 63'd1);
                        n_rsp.conflict_pid    = e.pid;
                        n_state = S_RES;
                    end else if (last) begin
                        n_state = S_RES;
                    end
                end else if (ev_abort) begin
                    n_state = S_RES;
                end else begin
                    n_q    = q;
                    n_qn   = qn;
                    n_qk   = '0;
                    n_ns   = m_ns;
                    n_ne   = m_ne;
                    n_done = ev_done;
                    if (qn != 2'd0) begin
                        n_state = S_EM;
                    end else if (last) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_EM: begin
                we     = 1'b1;
                n_wcnt = r_wcnt + CW'(1);
                n_qk   = r_qk + 2'd1;
                if (r_qk + 2'd1 == r_qn) begin
                    n_qk = '0;
                    n_state = (r_i == r_cnt) ? S_FIN : S_EV;
                end
            end
            S_FIN: begin
                n_bank  = !r_bank;
                n_cnt   = r_wcnt;
                n_state = S_RES;
            end
            S_RES: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_out    = r_rsp;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bank   <= 1'b0;
            r_cnt    <= '0;
            r_wcnt   <= '0;
            r_i      <= '0;
            r_done   <= 1'b0;
            r_qn     <= '0;
            r_qk     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bank   <= n_bank;
            r_cnt    <= n_cnt;
            r_wcnt   <= n_wcnt;
            r_i      <= n_i;
            r_done   <= n_done;
            r_qn     <= n_qn;
            r_qk     <= n_qk;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act <= n_act;
        r_own <= n_own;
        r_pid <= n_pid;
        r_nt  <= n_nt;
        r_ns  <= n_ns;
        r_ne  <= n_ne;
        r_q   <= n_q;
        r_rsp <= n_rsp;
        r_out <= n_out;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_LOCKS))
        else $error("Lock count exceeds the table size.");

    a_wcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EM) |-> (r_wcnt < CW'(MAX_LOCKS)))
        else $error("Write to the table beyond its size.");

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EM) |-> (r_qk < r_qn))
        else $error("Emit slot beyond the pending entries.");

endmodule

// ===== sim/tb_byte_range_lock_table.sv =====
`timescale 1ns / 1ps
// Testbench for the byte-range lock table: directed table and random requests checked by a predictor.
module tb_byte_range_lock_table;
    import brlt_pkg::*;

    localparam int NLOCK = 16;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;

    brlt_req_if req_ch ();
    brlt_rsp_if rsp_ch ();

    byte_range_lock_table #(.MAX_LOCKS(NLOCK)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    typedef struct {
        logic [63:0] owner;
        logic        is_write;
        logic [63:0] first;
        logic [63:0] last;
        logic [21:0] pid;
    } t_lock;

    typedef struct {
        t_req req;
        logic has_rsp;
        t_rsp rsp;
    } t_row;

    t_lock locks[$];
    t_rsp  pending_rsp[$];
    int    mismatches;
    int    cycles;
    int    send_idle_pct;
    int    recv_idle_pct;
    logic  running_done;

    // Returns the predicted result of one request and, for a set that is not refused, updates the lock list.
    function automatic t_rsp predict_lock(t_req r);
        t_rsp o;
        logic [1:0] nt;
        logic signed [64:0] ns;
        logic signed [64:0] ne;
        logic signed [64:0] lf;
        logic signed [64:0] ll;
        logic [63:0] e;
        int i;
        bit merged_in;
        t_lock nl;
        o = '0;
        nt = (r.lock_type == 2'd3) ? LT_UNLOCK : r.lock_type;
        if (r.length == 0) begin
            e = {1'b0, OFF_MAX};
        end else begin
            e = {1'b0, r.start_req} + {1'b0, r.length} - 64'd1;
            if (e > {1'b0, OFF_MAX}) e = {1'b0, OFF_MAX};
        end
        ns = {2'b0, r.start_req};
        ne = {1'b0, e};
        if (r.action == ACT_TEST) begin
            foreach (locks[k]) begin
                lf = {1'b0, locks[k].first};
                ll = {1'b0, locks[k].last};
                if (locks[k].owner != r.owner && ns <= ll && lf <= ne &&
                    (locks[k].is_write || nt == LT_WRITE)) begin
                    o.conflict_found = 1'b1;
                    o.conflict_type = locks[k].is_write;
                    o.conflict_start = locks[k].first[62:0];
                    o.conflict_length = (locks[k].last[62:0] == OFF_MAX) ? '0 :
                        63'(locks[k].last - locks[k].first + 64'd1);
                    o.conflict_pid = locks[k].pid;
                    break;
                end
            end
            return o;
        end
        if (!(nt == LT_UNLOCK && ns == 0 && ne == {2'b0, OFF_MAX}) &&
            locks.size() + 2 > NLOCK) begin
            o.status = 1'b1;
            return o;
        end
        i = 0;
        merged_in = 0;
        while (i < locks.size()) begin
            lf = {1'b0, locks[i].first};
            ll = {1'b0, locks[i].last};
            if (locks[i].owner != r.owner) begin
                i++;
                continue;
            end
            if ({1'b0, locks[i].is_write} == nt) begin
                if (ll < ns - 1) begin
                    i++;
                    continue;
                end
                if (ne < lf - 1) break;
                if (lf <= ns && ne <= ll) begin
                    merged_in = 1;
                    break;
                end
                if (lf < ns) ns = lf;
                if (ne < ll) ne = ll;
                locks.delete(i);
            end else begin
                if (ll < ns) begin
                    i++;
                    continue;
                end
                if (ne < lf) break;
                if (ns <= lf && ll <= ne) begin
                    locks.delete(i);
                    continue;
                end
                if (ll <= ne) begin
                    locks[i].last = 64'(ns - 1);
                    i++;
                    continue;
                end
                if (ns <= lf) begin
                    locks[i].first = 64'(ne + 1);
                    break;
                end
                nl = locks[i];
                nl.first = 64'(ne + 1);
                locks.insert(i + 1, nl);
                locks[i].last = 64'(ns - 1);
                i++;
            end
        end
        if (!merged_in && nt != LT_UNLOCK) begin
            nl.owner = r.owner;
            nl.is_write = (nt == LT_WRITE);
            nl.first = 64'(ns);
            nl.last = 64'(ne);
            nl.pid = r.pid;
            locks.insert(i, nl);
        end
        return o;
    endfunction

    function automatic t_req make_req(logic act, logic [63:0] own, logic [21:0] p,
                                      logic [1:0] lt, logic [62:0] s, logic [62:0] len);
        t_req r;
        r.action = act;
        r.owner = own;
        r.pid = p;
        r.lock_type = lt;
        r.start_req = s;
        r.length = len;
        return r;
    endfunction

    function automatic logic [62:0] rand63();
        return 63'({$urandom(), $urandom()});
    endfunction

    function automatic t_req random_req();
        t_req r;
        int mode;
        r.action = ($urandom_range(0, 99) < 55) ? ACT_SET : ACT_TEST;
        mode = $urandom_range(0, 9);
        r.owner = (mode == 0) ? {$urandom(), $urandom()} : 64'($urandom_range(1, 3));
        r.pid = 22'($urandom());
        r.lock_type = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        if (mode == 1) begin
            r.start_req = rand63();
            r.length = rand63() >> $urandom_range(0, 62);
        end else if (mode == 2) begin
            r.start_req = OFF_MAX - 63'($urandom_range(0, 40));
            r.length = 63'($urandom_range(0, 60));
        end else begin
            r.start_req = 63'($urandom_range(0, 200));
            r.length = ($urandom_range(0, 15) == 0) ? '0 : 63'($urandom_range(1, 40));
        end
        if (r.action == ACT_SET && r.lock_type != LT_READ && r.lock_type != LT_WRITE &&
            $urandom_range(0, 9) == 0) begin
            r.start_req = '0;
            r.length = '0;
        end
        return r;
    endfunction

    task automatic send_request(t_req r);
        t_rsp exp_rsp;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        exp_rsp = predict_lock(r);
        pending_rsp.push_back(exp_rsp);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", rsp_ch.data);
            end else begin
                exp_rsp = pending_rsp.pop_front();
                if (rsp_ch.data !== exp_rsp) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", exp_rsp, rsp_ch.data);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_byte_range_lock_table: FAIL");
            $finish;
        end
    end

    t_row rows[$];

    task automatic run_rows();
        t_rsp exp_rsp;
        foreach (rows[k]) begin
            send_request(rows[k].req);
            if (rows[k].has_rsp) begin
                exp_rsp = pending_rsp[$];
                if (exp_rsp !== rows[k].rsp) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row %0d: table says %p, predictor %p",
                                 k, rows[k].rsp, exp_rsp);
                end
            end
        end
    endtask

    function automatic t_row row(t_req r, logic has, t_rsp o);
        t_row w;
        w.req = r;
        w.has_rsp = has;
        w.rsp = o;
        return w;
    endfunction

    initial begin
        t_rsp z;
        t_rsp c;
        int phase;
        mismatches = 0;
        cycles = 0;
        send_idle_pct = 30;
        recv_idle_pct = 60;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        z = '0;
        c = '0;
        c.conflict_found = 1'b1;
        c.conflict_type = 1'b1;
        c.conflict_start = 63'd10;
        c.conflict_length = 63'd5;
        c.conflict_pid = 22'h3FFFFF;
        rows.push_back(row(make_req(ACT_TEST, 64'd1, 22'd0, LT_WRITE, 63'd0, 63'd0), 1, z));
        rows.push_back(row(make_req(ACT_SET, 64'd1, 22'h3FFFFF, LT_WRITE, 63'd10, 63'd5),
                           1, z));
        rows.push_back(row(make_req(ACT_TEST, 64'd2, 22'd0, LT_READ, 63'd0, 63'd0), 1, c));
        rows.push_back(row(make_req(ACT_TEST, 64'd1, 22'd0, LT_WRITE, 63'd0, 63'd0), 1, z));
        rows.push_back(row(make_req(ACT_SET, 64'd1, 22'd5, LT_WRITE, 63'd15, 63'd5), 0, z));
        rows.push_back(row(make_req(ACT_SET, 64'd1, 22'd5, LT_READ, 63'd12, 63'd2), 0, z));
        rows.push_back(row(make_req(ACT_SET, 64'd1, 22'd5, LT_WRITE, 63'd11, 63'd1), 0, z));
        rows.push_back(row(make_req(ACT_SET, 64'd2, 22'd7, LT_READ, 63'd0, 63'd0), 0, z));
        rows.push_back(row(make_req(ACT_TEST, 64'd3, 22'd0, LT_WRITE, OFF_MAX, 63'd1), 0, z));
        rows.push_back(row(make_req(ACT_TEST, 64'd3, 22'd0, 2'd3, 63'd0, 63'd100), 0, z));
        rows.push_back(row(make_req(ACT_TEST, 64'd3, 22'd0, LT_UNLOCK, 63'd0, 63'd100), 0, z));
        rows.push_back(row(make_req(ACT_SET, '1, 22'd1, LT_WRITE, OFF_MAX, OFF_MAX), 0, z));
        rows.push_back(row(make_req(ACT_TEST, 64'd0, 22'd0, LT_READ, OFF_MAX, 63'd0), 0, z));
        rows.push_back(row(make_req(ACT_SET, 64'd2, 22'd7, LT_UNLOCK, 63'd50, 63'd10), 0, z));
        rows.push_back(row(make_req(ACT_SET, 64'd2, 22'd7, 2'd3, 63'd0, 63'd20), 0, z));
        for (int k = 0; k < 8; k++)
            rows.push_back(row(make_req(ACT_SET, 64'(k + 10), 22'(k), LT_READ,
                                        63'(k * 3), 63'd1), 0, z));
        rows.push_back(row(make_req(ACT_SET, 64'd2, 22'd7, LT_UNLOCK, 63'd0, 63'd0), 0, z));
        run_rows();
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 60 : 0;
            recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 30 : 0;
            for (int n = 0; n < 160; n++) begin
                send_request(random_req());
                if ($urandom_range(0, 39) == 0)
                    for (int u = 1; u <= 3; u++)
                        send_request(make_req(ACT_SET, 64'(u), 22'd0, LT_UNLOCK, '0, '0));
            end
        end
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_byte_range_lock_table: PASS");
        end else begin
            $display("tb_byte_range_lock_table: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/brlt_pkg.sv
rtl/brlt_if.sv
rtl/byte_range_lock_table.sv
sim/tb_byte_range_lock_table.sv
